FILE: rtl/ssp_pkg.sv
// Shared types and constants for the size suffix parser.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 63;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [ValueW-1:0] value_t;

  typedef enum logic [3:0] {
    PH_INIT  = 4'd0,
    PH_NUM   = 4'd1,
    PH_K     = 4'd2,
    PH_M     = 4'd3,
    PH_G     = 4'd4,
    PH_B     = 4'd5,
    PH_BY    = 4'd6,
    PH_BYT   = 4'd7,
    PH_BYTE  = 4'd8,
    PH_BYTES = 4'd9,
    PH_ERR   = 4'd10
  } phase_e;

  localparam char_t ChSpace = 8'h20;
  localparam char_t ChZero  = 8'h30;
  localparam char_t ChNine  = 8'h39;
  localparam char_t ChUpA   = 8'h41;
  localparam char_t ChUpZ   = 8'h5a;
  localparam char_t ChCase  = 8'h20;
  localparam char_t ChK     = 8'h6b;
  localparam char_t ChM     = 8'h6d;
  localparam char_t ChG     = 8'h67;
  localparam char_t ChB     = 8'h62;
  localparam char_t ChY     = 8'h79;
  localparam char_t ChT     = 8'h74;
  localparam char_t ChE     = 8'h65;
  localparam char_t ChS     = 8'h73;

  localparam int unsigned ShiftK = 10;
  localparam int unsigned ShiftM = 20;
  localparam int unsigned ShiftG = 30;

endpackage

`default_nettype wire

FILE: rtl/ssp_char_step.sv
// Per-character update of parse phase and accumulator.
`timescale 1ns / 1ps
`default_nettype none

module ssp_char_step (
  input  ssp_pkg::phase_e phase_i,
  input  ssp_pkg::value_t acc_i,
  input  ssp_pkg::char_t  char_code_i,
  output ssp_pkg::phase_e phase_o,
  output ssp_pkg::value_t acc_o,
  output logic            accept_o
);
  import ssp_pkg::*;

  localparam int unsigned WideW = ValueW + 4;

  logic              is_digit;
  char_t             lc;
  logic [WideW-1:0]  acc_w;
  logic [WideW-1:0]  mul_sum;
  logic              mul_ovf;
  logic              ovf_k, ovf_m, ovf_g;

  assign is_digit = char_code_i inside {[ChZero:ChNine]};
  assign lc = (char_code_i inside {[ChUpA:ChUpZ]}) ?
              char_t'(char_code_i + ChCase) : char_code_i;

  // acc*10 + digit as two shifts and adds
  assign acc_w   = WideW'(acc_i);
  assign mul_sum = (acc_w << 3) + (acc_w << 1) + WideW'(char_code_i - ChZero);
  assign mul_ovf = |mul_sum[WideW-1:ValueW];

  assign ovf_k = |acc_i[ValueW-1:ValueW-ShiftK];
  assign ovf_m = |acc_i[ValueW-1:ValueW-ShiftM];
  assign ovf_g = |acc_i[ValueW-1:ValueW-ShiftG];

  always_comb begin
    phase_o = PH_ERR;
    acc_o   = acc_i;
    if (char_code_i == ChSpace) begin
      phase_o = phase_i;
    end else begin
      case (phase_i)
        PH_INIT, PH_NUM: begin
          if (is_digit) begin
            phase_o = mul_ovf ? PH_ERR : PH_NUM;
            acc_o   = mul_ovf ? acc_i : mul_sum[ValueW-1:0];
          end else if (phase_i == PH_NUM && lc == ChK) begin
            phase_o = ovf_k ? PH_ERR : PH_K;
            acc_o   = ovf_k ? acc_i : (acc_i << ShiftK);
          end else if (phase_i == PH_NUM && lc == ChM) begin
            phase_o = ovf_m ? PH_ERR : PH_M;
            acc_o   = ovf_m ? acc_i : (acc_i << ShiftM);
          end else if (phase_i == PH_NUM && lc == ChG) begin
            phase_o = ovf_g ? PH_ERR : PH_G;
            acc_o   = ovf_g ? acc_i : (acc_i << ShiftG);
          end
        end
        PH_K, PH_M, PH_G: phase_o = (lc == ChB) ? PH_B     : PH_ERR;
        PH_B:             phase_o = (lc == ChY) ? PH_BY    : PH_ERR;
        PH_BY:            phase_o = (lc == ChT) ? PH_BYT   : PH_ERR;
        PH_BYT:           phase_o = (lc == ChE) ? PH_BYTE  : PH_ERR;
        PH_BYTE:          phase_o = (lc == ChS) ? PH_BYTES : PH_ERR;
        default:          phase_o = PH_ERR;
      endcase
    end
  end

  always_comb begin
    case (phase_o)
      PH_NUM, PH_K, PH_M, PH_G, PH_B, PH_BYTE, PH_BYTES: accept_o = 1'b1;
      default: accept_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/size_suffix_parser.sv
// Size string parser top level: input register, parse state and result register.
//
// Usage: characters of a size string arrive one per request on the input
// channel (char_code_i, last_char_i). Spaces are ignored. On the request that
// carries last_char_i = 1 one result leaves on the output channel:
// size_value_o in bytes and parse_error_o (value is 0 on error). Other
// characters give no result.
// Throughput: one character per cycle while in_stall_o is low. The input
// register loads a character when it is accepted, then the parse state and
// result register update together when that character is consumed; a last
// character is not consumed while a result is stalled.
// Reset clears the parse state, the input register valid and the result valid.
// When the receiver stalls, the result holds; non-last characters keep
// flowing into the parse state, and a second last character waits in the
// input register, which then stalls the sender.
// After each result the parse state clears for the next string.
`timescale 1ns / 1ps
`default_nettype none

module size_suffix_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ssp_pkg::char_t  char_code_i,
  input  logic            last_char_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ssp_pkg::value_t size_value_o,
  output logic            parse_error_o
);
  import ssp_pkg::*;

  logic   in_vld_q;
  char_t  char_q;
  logic   last_q;
  phase_e phase_q, phase_d, phase_nx;
  value_t acc_q, acc_d, acc_nx;
  logic   ok_nx;
  logic   out_vld_q;
  value_t size_q;
  logic   err_q;
  logic   out_free;
  logic   consume;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign consume    = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !consume;

  ssp_char_step u_step (
    .phase_i     (phase_q),
    .acc_i       (acc_q),
    .char_code_i (char_q),
    .phase_o     (phase_nx),
    .acc_o       (acc_nx),
    .accept_o    (ok_nx)
  );

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    if (consume) begin
      phase_d = last_q ? PH_INIT : phase_nx;
      acc_d   = last_q ? '0 : acc_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_INIT;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      if (consume && last_q) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    if (consume && last_q) begin
      size_q <= ok_nx ? acc_nx : '0;
      err_q  <= !ok_nx;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign size_value_o  = size_q;
  assign parse_error_o = err_q;

endmodule

`default_nettype wire

FILE: rtl/ssp_checker.sv
// Port-level assertions for the size suffix parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssp_port_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input ssp_pkg::value_t size_value_o,
  input logic            parse_error_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(size_value_o)
      && $stable(parse_error_o))
    else $error("stalled result changed");

  // Error results carry zero size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_error_o |-> size_value_o == '0)
    else $error("error result with nonzero size");

  // Input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind size_suffix_parser ssp_port_checker u_ssp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .size_value_o  (size_value_o),
  .parse_error_o (parse_error_o)
);

`default_nettype wire
